[sv/lfe_pkg.sv]
`timescale 1ns / 1ps

package lfe_pkg;

  // effect codes carried in the input tuser
  typedef enum logic [2:0] {
    EFF_OFF     = 3'd0,
    EFF_FIXED   = 3'd1,
    EFF_FADE_IN = 3'd2,
    EFF_FADE_OUT = 3'd3,
    EFF_IN_OUT  = 3'd4
  } lfe_effect_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FADE_IN_TICKS  = 2'd0,
    REG_FADE_OUT_TICKS = 2'd1,
    REG_CYCLE_HALF     = 2'd2,
    REG_REFRESH_PERIOD = 2'd3
  } lfe_reg_e;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_DIV,
    ST_SCALE,
    ST_FIN
  } lfe_state_e;

  localparam int unsigned LFE_QDEPTH = 2;
  localparam int unsigned LFE_QPTR_W = 1;
  localparam int unsigned LFE_QCNT_W = 2;

  // one classified tick, handed from front to back
  typedef struct packed {
    logic [127:0] colours;     // group 1 in the lowest bits
    logic         hold;        // repeat the last sent frame
    logic         need_div;    // fade level comes from the divider
    logic         invert;      // fade = 255 - quotient
    logic [7:0]   const_fade;  // fade level when no division is needed
    logic [15:0]  num;         // step value to scale by 255
    logic [15:0]  den;         // duration register
  } lfe_job_t;

  // exact x / 255 for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] s;
    s = x + {8'd0, x[15:8]} + 16'd1;
    return s[15:8];
  endfunction

endpackage

[sv/lfe_front.sv]
`timescale 1ns / 1ps

module lfe_front import lfe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [2:0]   effect_i,
  input  logic [127:0] colours_i,
  input  logic [15:0]  fade_in_ticks_i,
  input  logic [15:0]  fade_out_ticks_i,
  input  logic [14:0]  cycle_half_ticks_i,
  input  logic         full_i,
  output logic         push_o,
  output lfe_job_t     job_o
);

  logic [2:0]  effect_q, effect_d;
  logic [15:0] step_q, step_d;
  logic [15:0] base;
  logic [15:0] half;
  logic [15:0] step_inc;
  logic        accept;

  assign ready_o  = !full_i;
  assign accept   = valid_i && !full_i;
  assign push_o   = accept;
  assign base     = (effect_i != effect_q) ? 16'd0 : step_q;
  assign half     = {1'b0, cycle_half_ticks_i};
  assign step_inc = base + 16'd1;

  // classify the tick and advance the step counter
  always_comb begin
    job_o.colours    = colours_i;
    job_o.hold       = 1'b0;
    job_o.need_div   = 1'b0;
    job_o.invert     = 1'b0;
    job_o.const_fade = 8'd0;
    job_o.num        = base;
    job_o.den        = 16'd0;
    effect_d         = effect_i;
    step_d           = base;
    unique case (effect_i)
      EFF_OFF: begin
        job_o.const_fade = 8'd0;
      end
      EFF_FIXED: begin
        job_o.const_fade = 8'hFF;
      end
      EFF_FADE_IN: begin
        if (base < fade_in_ticks_i) begin
          step_d = step_inc;
        end
        job_o.need_div = 1'b1;
        job_o.num      = step_d;
        job_o.den      = fade_in_ticks_i;
      end
      EFF_FADE_OUT: begin
        if (base < fade_out_ticks_i) begin
          step_d = step_inc;
        end
        job_o.need_div = 1'b1;
        job_o.invert   = 1'b1;
        job_o.den      = fade_out_ticks_i;
      end
      EFF_IN_OUT: begin
        job_o.need_div = 1'b1;
        job_o.den      = half;
        if (base >= half) begin
          job_o.num    = base - half;
          job_o.invert = 1'b1;
        end
        // wrap at twice the half cycle
        if (step_inc >= {cycle_half_ticks_i, 1'b0}) begin
          step_d = 16'd0;
        end else begin
          step_d = step_inc;
        end
      end
      default: begin
        job_o.hold = 1'b1;
      end
    endcase
  end

  // stored effect and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_q <= EFF_OFF;
      step_q   <= 16'd0;
    end else if (accept) begin
      effect_q <= effect_d;
      step_q   <= step_d;
    end
  end

endmodule

[sv/lfe_fifo.sv]
`timescale 1ns / 1ps

module lfe_fifo import lfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lfe_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output lfe_job_t data_o
);

  lfe_job_t              mem_q [LFE_QDEPTH];
  logic [LFE_QPTR_W-1:0] wr_q, rd_q;
  logic [LFE_QCNT_W-1:0] count_q;

  assign full_o  = (count_q == LFE_QCNT_W'(LFE_QDEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // fill level stays in range and tracks lone pushes and pops
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LFE_QCNT_W'(LFE_QDEPTH))
    else $error("queue fill level out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill level did not grow on push");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue fill level did not shrink on pop");

endmodule

[sv/lfe_back.sv]
`timescale 1ns / 1ps

module lfe_back import lfe_pkg::*; #(
  parameter int unsigned GROUPS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  lfe_job_t     job_i,
  output logic         pop_o,
  input  logic [15:0]  refresh_period_i,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned CH   = 4 * GROUPS;
  localparam int unsigned CH_W = $clog2(CH);

  lfe_state_e       state_q, state_d;
  lfe_job_t         job_q;
  logic [23:0]      num_q;
  logic [23:0]      rem_q;
  logic [23:0]      dsh_q;
  logic [7:0]       quo_q;
  logic [2:0]       bit_q;
  logic [7:0]       fade_q;
  logic [CH_W-1:0]  ch_q;
  logic [7:0]       frame_q [CH];
  logic [7:0]       last_sent_q [CH];
  logic             diff_q;
  logic [15:0]      unchanged_q;
  logic             out_valid_q;
  logic [127:0]     out_data_q;
  logic             out_send_q;

  logic             sat;
  logic             ge;
  logic [7:0]       quo_d;
  logic [15:0][7:0] col_bytes;
  logic [7:0]       col;
  logic [15:0]      prod;
  logic [7:0]       chan_val;
  logic             out_free;
  logic             send;
  logic             load_out;
  logic [127:0]     frame_flat;

  // datapath helpers
  assign sat       = (num_q >= {job_q.den, 8'd0});
  assign ge        = (rem_q >= dsh_q);
  assign quo_d     = {quo_q[6:0], ge};
  assign col_bytes = job_q.colours;
  assign col       = col_bytes[4'(ch_q)];
  assign prod      = col * fade_q;
  assign chan_val  = job_q.hold ? last_sent_q[ch_q] : div255(prod);
  assign send      = diff_q || (unchanged_q >= refresh_period_i);

  always_comb begin
    frame_flat = '0;
    for (int i = 0; i < CH; i++) begin
      frame_flat[i*8 +: 8] = frame_q[i];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = job_i.need_div ? ST_MUL : ST_SCALE;
        end
      end
      ST_MUL: state_d = ST_SAT;
      ST_SAT: state_d = sat ? ST_SCALE : ST_DIV;
      ST_DIV: begin
        if (bit_q == 3'd0) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (ch_q == CH_W'(CH - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer strobes
  always_comb begin
    out_free = !out_valid_q || m_axis_tready;
    pop_o    = (state_q == ST_IDLE) && !empty_i;
    load_out = (state_q == ST_FIN) && out_free;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      bit_q       <= 3'd0;
      unchanged_q <= 16'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CH; i++) begin
        last_sent_q[i] <= 8'd0;
      end
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        ch_q <= '0;
      end else if (state_q == ST_SCALE) begin
        ch_q <= ch_q + 1'b1;
      end
      if (state_q == ST_SAT) begin
        bit_q <= 3'd7;
      end else if (state_q == ST_DIV) begin
        bit_q <= bit_q - 3'd1;
      end
      // resend bookkeeping
      if (load_out) begin
        if (send) begin
          unchanged_q <= 16'd0;
          for (int i = 0; i < CH; i++) begin
            last_sent_q[i] <= frame_q[i];
          end
        end else begin
          unchanged_q <= unchanged_q + 16'd1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // fade level, division and channel scaling
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q  <= job_i;
      fade_q <= job_i.const_fade;
      diff_q <= 1'b0;
    end
    if (state_q == ST_MUL) begin
      num_q <= {job_q.num, 8'd0} - {8'd0, job_q.num};
    end
    if (state_q == ST_SAT) begin
      rem_q <= num_q;
      dsh_q <= {1'b0, job_q.den, 7'd0};
      quo_q <= 8'd0;
      if (sat) begin
        fade_q <= job_q.invert ? 8'd0 : 8'hFF;
      end
    end
    if (state_q == ST_DIV) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= quo_d;
      if (bit_q == 3'd0) begin
        fade_q <= job_q.invert ? ~quo_d : quo_d;
      end
    end
    if (state_q == ST_SCALE) begin
      frame_q[ch_q] <= chan_val;
      diff_q        <= diff_q | (chan_val != last_sent_q[ch_q]);
    end
    if (load_out) begin
      out_data_q <= frame_flat;
      out_send_q <= send;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_send_q;

  // a new word only appears after the send decision
  a_valid_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("output word raised outside the final step");

  // unchanged frame not sent bumps the refresh count
  a_unchanged_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !send) |=> unchanged_q == $past(unchanged_q) + 16'd1)
    else $error("refresh count did not advance");

  // sent frame becomes the reference
  a_send_updates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && send) |=> (unchanged_q == 16'd0) && (last_sent_q[0] == $past(frame_q[0])))
    else $error("sent frame not recorded");

endmodule

[sv/led_fade_effect_engine.sv]
`timescale 1ns / 1ps

// LED fade effect engine: each input word is one effect tick (effect code in tuser, four
// RGBW colour groups in tdata) and yields one output word with the 16 scaled channels in
// tdata and the send flag in tuser. The front end takes a tick in any cycle where its
// two-entry queue has room and advances the effect step counter right away; the back end
// works one tick at a time: it picks up the tick, forms the 255x product, checks for
// saturation, runs the 8-bit restoring divider, steps the 4*GROUPS channels through the
// single channel multiplier and then makes the send decision, waiting as needed for the
// output register to drain. Fading effects take every step; when the quotient saturates
// the divider is skipped, and off, fixed and unknown codes skip the product, the
// saturation check and the divider. Configuration registers must be written only
// while the engine is idle.
module led_fade_effect_engine import lfe_pkg::*; #(
  parameter int unsigned GROUPS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // group1_rgbw, group2_rgbw, group3_rgbw, group4_rgbw
  input  logic [2:0]   s_axis_tuser,   // effect
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // out_group1, out_group2, out_group3, out_group4
  output logic [0:0]   m_axis_tuser,   // send_frame
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  logic [15:0] fade_in_ticks_q;
  logic [15:0] fade_out_ticks_q;
  logic [14:0] cycle_half_ticks_q;
  logic [15:0] refresh_period_q;

  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  lfe_job_t    q_wdata;
  lfe_job_t    q_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_in_ticks_q    <= 16'd10000;
      fade_out_ticks_q   <= 16'd10000;
      cycle_half_ticks_q <= 15'd1000;
      refresh_period_q   <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FADE_IN_TICKS:  fade_in_ticks_q    <= cfg_data_i;
        REG_FADE_OUT_TICKS: fade_out_ticks_q   <= cfg_data_i;
        REG_CYCLE_HALF:     cycle_half_ticks_q <= cfg_data_i[14:0];
        REG_REFRESH_PERIOD: refresh_period_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tick classification and step counter
  lfe_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (s_axis_tvalid),
    .ready_o            (s_axis_tready),
    .effect_i           (s_axis_tuser),
    .colours_i          (s_axis_tdata),
    .fade_in_ticks_i    (fade_in_ticks_q),
    .fade_out_ticks_i   (fade_out_ticks_q),
    .cycle_half_ticks_i (cycle_half_ticks_q),
    .full_i             (q_full),
    .push_o             (q_push),
    .job_o              (q_wdata)
  );

  // queue between front and back
  lfe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  // fade level, channel scaling and send decision
  lfe_back #(
    .GROUPS (GROUPS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (q_empty),
    .job_i            (q_rdata),
    .pop_o            (q_pop),
    .refresh_period_i (refresh_period_q),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser)
  );

endmodule
